FILE: design/aps_pkg.sv
// Shared types and constants of the Annex-B parameter set extractor.
`timescale 1ns / 1ps
`default_nettype none
package aps_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgKeepFirst  = 2'd0;
  localparam logic [1:0] CfgKeepSecond = 2'd1;
  localparam logic [1:0] CfgCapacity   = 2'd2;

  // Register reset values
  localparam logic [4:0]  KeepFirstRst  = 5'd7;   // sequence parameter set
  localparam logic [4:0]  KeepSecondRst = 5'd8;   // picture parameter set
  localparam logic [16:0] CapacityRst   = 17'd65536;

  localparam logic [4:0] TypeMask = 5'h1F;

  // Largest value of the 17-bit length field
  localparam int LenMax = 131071;

  // Command queue between classifier and emitter
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Emitter step positions: decided byte, four flush bytes, end marker
  localparam logic [2:0] PosDecided = 3'd0;
  localparam logic [2:0] PosMarker  = 3'd5;

  // One classified input transfer
  typedef struct packed {
    logic [3:0][7:0] flush_bytes;  // undecided bytes at packet end, oldest in [0]
    logic [2:0]      flush_cnt;    // 1..4
    logic            last;         // packet end: flush, then marker
    logic            keep;         // bytes belong to a kept unit
    logic            dec_vld;      // a byte was decided by this transfer
    logic [7:0]      dec_byte;
  } entry_t;

endpackage
`default_nettype wire

FILE: design/aps_front.sv
// Classifier: lookahead window, start code search and unit type match.
`timescale 1ns / 1ps
`default_nettype none
module aps_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_vld_i,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          in_last_i,
  input  wire logic          q_full_i,
  input  wire logic [4:0]    keep_first_i,
  input  wire logic [4:0]    keep_second_i,
  output logic               in_rdy_o,
  output logic               push_o,
  output aps_pkg::entry_t    entry_o
);

  logic [3:0][7:0] win_q, win_d;
  logic [2:0]      fill_q, fill_d;
  logic            keep_q, keep_d;
  logic            accept;
  logic            full_win;
  logic            start_code;
  logic            type_hit;
  logic [4:0]      hdr_type;
  logic [3:0][7:0] win_n;

  assign in_rdy_o = !q_full_i;
  assign accept   = in_vld_i && !q_full_i;
  assign full_win = (fill_q == 3'd4);

  // Start code sits in the four oldest bytes, the new byte is its header
  assign start_code = (win_q[0] == 8'h00) && (win_q[1] == 8'h00) &&
                      (win_q[2] == 8'h00) && (win_q[3] == 8'h01);
  assign hdr_type   = in_byte_i[4:0] & aps_pkg::TypeMask;
  assign type_hit   = (hdr_type == keep_first_i) || (hdr_type == keep_second_i);

  always_comb begin
    win_n  = win_q;
    keep_d = keep_q;
    if (full_win) begin
      win_n = {in_byte_i, win_q[3], win_q[2], win_q[1]};
      if (start_code) begin
        keep_d = type_hit;
      end
    end else begin
      win_n[fill_q[1:0]] = in_byte_i;
    end

    entry_o.flush_bytes = win_n;
    entry_o.flush_cnt   = full_win ? 3'd4 : 3'(fill_q + 3'd1);
    entry_o.last        = in_last_i;
    entry_o.keep        = keep_d;
    entry_o.dec_vld     = full_win;
    entry_o.dec_byte    = win_q[0];

    win_d  = win_q;
    fill_d = fill_q;
    if (accept) begin
      win_d  = win_n;
      fill_d = full_win ? 3'd4 : 3'(fill_q + 3'd1);
      if (in_last_i) begin
        fill_d = 3'd0;
        keep_d = 1'b0;
      end
    end else begin
      keep_d = keep_q;
    end
  end

  assign push_o = accept && (full_win || in_last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 3'd0;
      keep_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      keep_q <= keep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule
`default_nettype wire

FILE: design/aps_fifo.sv
// Small command queue between classifier and emitter.
`timescale 1ns / 1ps
`default_nettype none
module aps_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire aps_pkg::entry_t push_data_i,
  input  wire logic          pop_i,
  output aps_pkg::entry_t    head_o,
  output logic               empty_o,
  output logic               full_o
);

  aps_pkg::entry_t                  mem_q [aps_pkg::QDepth];
  logic [aps_pkg::QPtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [aps_pkg::QCntW-1:0]        cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == aps_pkg::QCntW'(aps_pkg::QDepth));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

FILE: design/aps_back.sv
// Emitter: capacity accounting, byte output and end-of-packet marker.
`timescale 1ns / 1ps
`default_nettype none
module aps_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire aps_pkg::entry_t head_i,
  input  wire logic          empty_i,
  input  wire logic [16:0]   cap_i,
  output logic               pop_o,
  output logic               out_vld_o,
  input  wire logic          out_rdy_i,
  output logic [7:0]         out_byte_o,
  output logic               out_bvld_o,
  output logic               out_last_o,
  output logic               out_found_o,
  output logic [16:0]        out_len_o,
  output logic               out_ovf_o
);

  logic [2:0]  pos_q, pos_d;
  logic [16:0] written_q, written_d;
  logic        ovf_q, ovf_d;
  logic        out_vld_q, out_vld_d;
  logic [7:0]  ob_q;
  logic        obv_q, olast_q, ofnd_q, oovf_q;
  logic [16:0] olen_q;

  logic        is_marker, byte_here, has_room;
  logic        emit_byte, emit_marker, drop_byte, need_slot, slot_free, step;
  logic [1:0]  fidx;
  logic [7:0]  cur_byte;

  assign is_marker = (pos_q == aps_pkg::PosMarker);
  assign fidx      = 2'(pos_q - 3'd1);
  assign cur_byte  = (pos_q == aps_pkg::PosDecided) ? head_i.dec_byte
                                                    : head_i.flush_bytes[fidx];
  assign byte_here = (pos_q == aps_pkg::PosDecided) ? head_i.dec_vld
                   : (!is_marker && head_i.last && (pos_q <= head_i.flush_cnt));
  assign has_room  = (written_q < cap_i);

  assign emit_byte   = !empty_i && byte_here && head_i.keep && has_room;
  assign drop_byte   = !empty_i && byte_here && head_i.keep && !has_room;
  assign emit_marker = !empty_i && is_marker;
  assign need_slot   = emit_byte || emit_marker;
  assign slot_free   = !out_vld_q || out_rdy_i;
  assign step        = !empty_i && (!need_slot || slot_free);

  always_comb begin
    pos_d     = pos_q;
    pop_o     = 1'b0;
    written_d = written_q;
    ovf_d     = ovf_q;
    out_vld_d = out_vld_q && !out_rdy_i;
    if (step) begin
      if (is_marker || !head_i.last) begin
        pop_o = 1'b1;
        pos_d = aps_pkg::PosDecided;
      end else if (pos_q < head_i.flush_cnt) begin
        pos_d = pos_q + 3'd1;
      end else begin
        pos_d = aps_pkg::PosMarker;
      end
      if (emit_byte) written_d = written_q + 17'd1;
      if (drop_byte) ovf_d = 1'b1;
      if (emit_marker) begin
        written_d = '0;
        ovf_d     = 1'b0;
      end
      if (need_slot) out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= aps_pkg::PosDecided;
      written_q <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      written_q <= written_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && need_slot) begin
      ob_q    <= emit_marker ? 8'h00 : cur_byte;
      obv_q   <= emit_byte;
      olast_q <= emit_marker;
      ofnd_q  <= emit_marker && ((written_q != '0) || ovf_q);
      olen_q  <= emit_marker ? written_q : '0;
      oovf_q  <= emit_marker && ovf_q;
    end
  end

  assign out_vld_o   = out_vld_q;
  assign out_byte_o  = ob_q;
  assign out_bvld_o  = obv_q;
  assign out_last_o  = olast_q;
  assign out_found_o = ofnd_q;
  assign out_len_o   = olen_q;
  assign out_ovf_o   = oovf_q;

`ifndef SYNTH
  a_len_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    written_q <= cap_i) else $error("written count above capacity");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= aps_pkg::PosMarker) else $error("emitter position out of range");

  a_marker_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && emit_marker) |=> (written_q == '0) && !ovf_q)
    else $error("packet state not cleared after marker");
`endif

endmodule
`default_nettype wire

FILE: design/annexb_parameter_set_extractor.sv
// Top level of the Annex-B parameter set extractor.
`timescale 1ns / 1ps
`default_nettype none
// Scans an Annex-B byte stream (one byte per transfer, tlast on the packet's
// last byte) for units that start at 00 00 00 01 plus a header byte, and
// passes on, byte for byte and including the start code, every unit whose
// header type (header AND 0x1F) matches keep_type_first or keep_type_second.
// After each packet one marker transfer (tuser 0, tlast 1) carries found,
// total_length and overflow. A byte is decided four bytes late, so at packet
// end the classifier hands the emitter up to four undecided bytes at once.
// Throughput: one input byte per cycle while the command queue has room. The
// classifier takes a byte every cycle while its four-entry command queue has
// room; the emitter retires one command per cycle for ordinary bytes while the
// output is free, and a packet-end command goes through its steps (decided
// byte, four flush bytes, marker) one at a time, limited by the single output
// register. Configuration writes are always taken (cfg_ready_o is high); index
// 3 is ignored. out_capacity is clamped to MAX_OUTPUT_BYTES, at most 131071;
// kept bytes past it are dropped and flagged.
module annexb_parameter_set_extractor #(
  parameter int MAX_OUTPUT_BYTES = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // packet_end
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] out_byte, [8] found,
                                           // [25:9] total_length, [26] overflow
  output logic             m_axis_tuser,   // byte_valid
  output logic             m_axis_tlast,   // run_last
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i
);

  localparam int CapLimit = (MAX_OUTPUT_BYTES < aps_pkg::LenMax) ? MAX_OUTPUT_BYTES
                                                                 : aps_pkg::LenMax;
  localparam logic [16:0] CapLimitW = 17'(CapLimit);

  logic [4:0]  keep_first_q, keep_second_q;
  logic [16:0] cap_cfg_q;
  logic [16:0] cap_eff;

  aps_pkg::entry_t push_entry, head_entry;
  logic            push, pop, q_empty, q_full;

  logic [7:0]  o_byte;
  logic        o_bvld, o_last, o_fnd, o_ovf;
  logic [16:0] o_len;

  // Config registers; the host must write them only while the block is idle (not enforced here)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_first_q  <= aps_pkg::KeepFirstRst;
      keep_second_q <= aps_pkg::KeepSecondRst;
      cap_cfg_q     <= aps_pkg::CapacityRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        aps_pkg::CfgKeepFirst:  keep_first_q  <= cfg_data_i[4:0];
        aps_pkg::CfgKeepSecond: keep_second_q <= cfg_data_i[4:0];
        aps_pkg::CfgCapacity:   cap_cfg_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cap_eff = (cap_cfg_q > CapLimitW) ? CapLimitW : cap_cfg_q;

  aps_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_vld_i      (s_axis_tvalid),
    .in_byte_i     (s_axis_tdata),
    .in_last_i     (s_axis_tlast),
    .q_full_i      (q_full),
    .keep_first_i  (keep_first_q),
    .keep_second_i (keep_second_q),
    .in_rdy_o      (s_axis_tready),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  aps_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .head_o      (head_entry),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  aps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_entry),
    .empty_i     (q_empty),
    .cap_i       (cap_eff),
    .pop_o       (pop),
    .out_vld_o   (m_axis_tvalid),
    .out_rdy_i   (m_axis_tready),
    .out_byte_o  (o_byte),
    .out_bvld_o  (o_bvld),
    .out_last_o  (o_last),
    .out_found_o (o_fnd),
    .out_len_o   (o_len),
    .out_ovf_o   (o_ovf)
  );

  assign m_axis_tdata = {5'd0, o_ovf, o_len, o_fnd, o_byte};
  assign m_axis_tuser = o_bvld;
  assign m_axis_tlast = o_last;

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for the Annex-B parameter set extractor: stimulus, prediction and checks.
`timescale 1ns / 1ps

typedef logic [7:0] byte_q_t[$];

// One output transfer, split into its fields
typedef struct packed {
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        run_last;
  logic        found;
  logic [16:0] total_length;
  logic        overflow;
} aps_result_t;

// Tracks the unit filter from the accepted input bytes and holds the output
// transfers it still expects, oldest first.
class extract_scoreboard;
  int unsigned max_bytes;
  logic [4:0]  keep_a;
  logic [4:0]  keep_b;
  logic [16:0] capacity;
  logic [7:0]  window[5];
  int          fill;
  bit          in_unit;
  bit          keeping;
  bit          ovf_seen;
  int unsigned written;
  aps_result_t expected_out[$];
  int          errors;

  function new(int unsigned max_bytes);
    this.max_bytes = max_bytes;
    keep_a   = aps_pkg::KeepFirstRst;
    keep_b   = aps_pkg::KeepSecondRst;
    capacity = aps_pkg::CapacityRst;
    errors   = 0;
    start_packet();
  endfunction

  function void start_packet();
    foreach (window[i]) window[i] = 8'h00;
    fill     = 0;
    in_unit  = 1'b0;
    keeping  = 1'b0;
    written  = 0;
    ovf_seen = 1'b0;
  endfunction

  function void set_register(logic [1:0] idx, logic [16:0] value);
    case (idx)
      aps_pkg::CfgKeepFirst:  keep_a = value[4:0];
      aps_pkg::CfgKeepSecond: keep_b = value[4:0];
      aps_pkg::CfgCapacity:   capacity = value;
      default: ;  // unknown index: write is dropped
    endcase
  endfunction

  // A byte of the current unit goes out only while the unit is kept and
  // there is room left in the destination.
  function void emit_byte(logic [7:0] b);
    aps_result_t r;
    int unsigned cap;
    if (!(in_unit && keeping)) return;
    cap = (capacity > max_bytes) ? max_bytes : capacity;
    if (written < cap) begin
      r = '0;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      expected_out.push_back(r);
      written++;
    end else begin
      ovf_seen = 1'b1;
    end
  endfunction

  function void take_byte(logic [7:0] b, bit pkt_end);
    aps_result_t r;
    if (fill > 4) fill = 4;
    window[fill] = b;
    fill++;
    // Oldest byte is decided once four more have arrived
    if (fill == 5) begin
      if (window[0] == 8'h00 && window[1] == 8'h00 && window[2] == 8'h00 &&
          window[3] == 8'h01) begin
        in_unit = 1'b1;
        keeping = (window[4][4:0] == keep_a) || (window[4][4:0] == keep_b);
      end
      emit_byte(window[0]);
      for (int i = 0; i < 4; i++) window[i] = window[i + 1];
      window[4] = 8'h00;
      fill = 4;
    end
    if (pkt_end) begin
      // undecided tail belongs to the current unit
      for (int i = 0; i < fill; i++) emit_byte(window[i]);
      r = '0;
      r.run_last     = 1'b1;
      r.found        = (written > 0) || ovf_seen;
      r.total_length = written[16:0];
      r.overflow     = ovf_seen;
      expected_out.push_back(r);
      start_packet();
    end
  endfunction

  function void check_output(aps_result_t got);
    aps_result_t want;
    if (expected_out.size() == 0) begin
      $error("unexpected output transfer: out_byte %h byte_valid %b run_last %b",
             got.out_byte, got.byte_valid, got.run_last);
      errors++;
      return;
    end
    want = expected_out.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
      errors++;
    end
    if (got.byte_valid !== want.byte_valid) begin
      $error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
      errors++;
    end
    if (got.run_last !== want.run_last) begin
      $error("run_last: expected %b, got %b", want.run_last, got.run_last);
      errors++;
    end
    if (got.found !== want.found) begin
      $error("found: expected %b, got %b", want.found, got.found);
      errors++;
    end
    if (got.total_length !== want.total_length) begin
      $error("total_length: expected %0d, got %0d", want.total_length, got.total_length);
      errors++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %b, got %b", want.overflow, got.overflow);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int MaxOutBytes = 65536;
  localparam logic [1:0] CfgUnused = 2'd3;  // index with no register behind it

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [16:0] cfg_data_i = 17'd0;

  extract_scoreboard sb;
  bit rx_hold = 1'b0;  // asks the receiver for one long hold-off

  annexb_parameter_set_extractor #(
    .MAX_OUTPUT_BYTES(MaxOutBytes)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial forever #6 clk_i = ~clk_i;

  // Output monitor: every accepted transfer is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_output({m_axis_tdata[7:0], m_axis_tuser, m_axis_tlast, m_axis_tdata[8],
                       m_axis_tdata[25:9], m_axis_tdata[26]});
    end
  end

  // Receiver: random wait before each transfer, with runs of no waiting
  initial begin
    int gap;
    int count;
    bit eager;
    wait (rst_ni);
    eager = 1'b0;
    count = 0;
    gap = $urandom_range(0, 17);
    forever begin
      if (rx_hold) begin
        gap = 90;
        rx_hold = 1'b0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      count++;
      if (count % 16 == 0) eager = ($urandom_range(0, 2) == 0);
      gap = eager ? 0 : $urandom_range(0, 17);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk_i);
  endtask

  task automatic send_packet(input byte_q_t bytes, input bit eager);
    int gap;
    bit pkt_end;
    for (int i = 0; i < bytes.size(); i++) begin
      gap = eager ? 0 : $urandom_range(0, 17);
      pkt_end = (i == bytes.size() - 1);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= bytes[i];
      s_axis_tlast  <= pkt_end;
      do @(posedge clk_i); while (!s_axis_tready);
      sb.take_byte(bytes[i], pkt_end);
    end
  endtask

  // Stop sending and let every predicted transfer come out, then keep
  // waiting so the emitter is surely empty before any register write.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_out.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Mostly zeros and ones so that start codes turn up inside payloads
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0, 1:    return 8'h00;
      2:       return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  // Junk, then whole units whose header mostly matches a kept type,
  // sometimes a cut-off start code at the tail.
  function automatic byte_q_t make_packet(logic [4:0] ka, logic [4:0] kb);
    byte_q_t p;
    int units;
    logic [7:0] hdr;
    repeat ($urandom_range(0, 3)) p.push_back(noise_byte());
    units = $urandom_range(0, 3);
    for (int u = 0; u < units; u++) begin
      p.push_back(8'h00);
      p.push_back(8'h00);
      p.push_back(8'h00);
      p.push_back(8'h01);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: hdr = {3'($urandom_range(0, 7)), ka};
        4, 5, 6:    hdr = {3'($urandom_range(0, 7)), kb};
        default:    hdr = 8'($urandom);
      endcase
      p.push_back(hdr);
      repeat ($urandom_range(0, 8)) p.push_back(noise_byte());
    end
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) p.push_back(8'h00);
      if ($urandom_range(0, 1) == 1) p.push_back(8'h01);
    end
    if (p.size() == 0) p.push_back(noise_byte());
    return p;
  endfunction

  // Capacity walks through its extremes across the phases
  task automatic random_config(input int phase);
    logic [16:0] cap;
    case (phase % 7)
      0:       cap = 17'd0;
      1:       cap = 17'd1;
      2:       cap = 17'($urandom_range(2, 24));
      3:       cap = 17'd65535;
      4:       cap = 17'd65536;
      5:       cap = 17'h1FFFF;  // above the parameter, clamped
      default: cap = 17'($urandom);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      write_reg(aps_pkg::CfgKeepFirst, {12'($urandom), aps_pkg::KeepFirstRst});
      write_reg(aps_pkg::CfgKeepSecond, {12'($urandom), aps_pkg::KeepSecondRst});
    end else begin
      write_reg(aps_pkg::CfgKeepFirst, 17'($urandom));
      write_reg(aps_pkg::CfgKeepSecond, 17'($urandom));
    end
    write_reg(aps_pkg::CfgCapacity, cap);
    if ($urandom_range(0, 3) == 0) write_reg(CfgUnused, 17'($urandom));
  endtask

  initial begin
    byte_q_t pkt;
    int phase;
    int sent;
    sb = new(MaxOutBytes);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a packet too short to hold a unit, then junk ahead of
    // a kept SPS, an unkept unit whose header starts the next start code,
    // and a kept PPS.
    pkt = '{8'h00, 8'h00, 8'h00, 8'h01};
    send_packet(pkt, 1'b0);
    pkt = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h00, 8'h01,
            8'h00, 8'h00, 8'h00, 8'h01, 8'h68, 8'hAB};
    send_packet(pkt, 1'b0);
    wait_idle();

    // Type extremes 0 and 31 (upper data bits ignored), capacity exhausted
    // mid-unit, write to the unknown index.
    write_reg(aps_pkg::CfgKeepFirst, 17'h1FFE0);
    write_reg(aps_pkg::CfgKeepSecond, 17'h0001F);
    write_reg(aps_pkg::CfgCapacity, 17'd3);
    write_reg(CfgUnused, 17'h1ABCD);
    pkt = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hE0, 8'h11};
    send_packet(pkt, 1'b0);
    wait_idle();

    // Zero capacity: the kept unit is found only through its dropped bytes
    write_reg(aps_pkg::CfgCapacity, 17'd0);
    pkt = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
    send_packet(pkt, 1'b0);
    wait_idle();

    // Random phases; in phase 4 the receiver holds off while bytes stream in
    phase = 0;
    sent = 0;
    while (sent < 230 || phase < 7) begin
      random_config(phase);
      if (phase == 4) rx_hold = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        pkt = make_packet(sb.keep_a, sb.keep_b);
        send_packet(pkt, phase == 4 || $urandom_range(0, 2) == 0);
        sent += pkt.size();
      end
      wait_idle();
      phase++;
    end

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: annexb_parameter_set_extractor.f
design/aps_pkg.sv
design/aps_front.sv
design/aps_fifo.sv
design/aps_back.sv
design/annexb_parameter_set_extractor.sv
dv/tb_top.sv
